>>> src/tps_pkg.sv
// Shared widths, constants and codes for the tree parent selector.
package tps_pkg;

    localparam int unsigned NODE_W      = 16;
    localparam int unsigned HOPS_W      = 16;
    localparam int unsigned QUAL_W      = 16;
    localparam int unsigned COMP_W      = 16;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned IN_DATA_W   = 72;
    localparam int unsigned OUT_DATA_W  = 24;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [NODE_W-1:0] NO_NODE      = 16'hFFFF;
    localparam logic [HOPS_W-1:0] NO_HOPS      = 16'hFFFF;
    localparam logic [QUAL_W-1:0] MARGIN_RESET = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_IS_SINK        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUALITY_MARGIN = 1'd1;

    localparam logic [STATUS_W-1:0] ST_FORWARD  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ROUTE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LOCAL    = 2'd2;

    typedef struct packed {
        logic [QUAL_W-1:0] link_quality;
        logic [HOPS_W-1:0] hop_distance;
        logic [COMP_W-1:0] component_id;
        logic              link_bidirectional;
        logic [NODE_W-1:0] neighbor_id;
    } entry_t;

endpackage

>>> src/tree_parent_selector_unit.sv
// Top level: neighbour table scan and parent decision with quality hysteresis.
// Result path: an accepted last beat waits in the entry register until the result
// register is empty or being read, then its result is registered there.
// Throughput: one table entry per cycle; a last beat waits in the entry register
// while the previous result beat is held by the receiver.
// Reset: parent 0xFFFF, scan state cleared, is_sink 0, quality_margin 1000.
module tree_parent_selector_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // neighbor_id[15:0], link_bidirectional[16], component_id[32:17],
    // hop_distance[48:33], link_quality[64:49], zero[71:65]
    input  logic [tps_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // next_hop[15:0], route_status[17:16], parent_changed[18], zero[23:19]
    output logic [tps_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             cfg_we,
    input  logic [tps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tps_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tps_pkg::*;

    logic                is_sink_reg;
    logic [QUAL_W-1:0]   margin_reg;

    logic                in_valid_reg;
    entry_t              in_entry_reg;
    logic                in_last_reg;

    logic [NODE_W-1:0]   parent_reg, parent_next;
    logic [NODE_W-1:0]   best_id_reg, best_id_next;
    logic [QUAL_W-1:0]   best_qual_reg, best_qual_next;
    logic [HOPS_W-1:0]   best_hops_reg, best_hops_next;
    logic [QUAL_W-1:0]   par_qual_reg, par_qual_next;
    logic [HOPS_W-1:0]   par_hops_reg, par_hops_next;

    logic                out_valid_reg;
    logic [NODE_W-1:0]   out_hop_reg, out_hop_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_changed_reg, out_changed_next;

    logic                fire;
    logic                counts;
    logic                replace;
    logic [QUAL_W:0]     qual_limit;

    assign fire     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_comb
    begin
        counts         = in_entry_reg.link_bidirectional &&
                         (in_entry_reg.component_id == '0);
        best_id_next   = best_id_reg;
        best_qual_next = best_qual_reg;
        best_hops_next = best_hops_reg;
        par_qual_next  = par_qual_reg;
        par_hops_next  = par_hops_reg;
        if (counts)
        begin
            if (in_entry_reg.neighbor_id == parent_reg)
            begin
                par_qual_next = in_entry_reg.link_quality;
                par_hops_next = in_entry_reg.hop_distance;
            end
            if ((in_entry_reg.hop_distance < best_hops_reg) ||
                ((in_entry_reg.hop_distance == best_hops_reg) &&
                 (in_entry_reg.link_quality > best_qual_reg)))
            begin
                best_id_next   = in_entry_reg.neighbor_id;
                best_qual_next = in_entry_reg.link_quality;
                best_hops_next = in_entry_reg.hop_distance;
            end
        end

        qual_limit = {1'b0, par_qual_next} + {1'b0, margin_reg};
        replace    = (par_qual_next == '0) ||
                     (best_hops_next < par_hops_next) ||
                     ((best_hops_next == par_hops_next) &&
                      ({1'b0, best_qual_next} > qual_limit));

        parent_next      = replace ? best_id_next : parent_reg;
        out_hop_next     = parent_next;
        out_status_next  = (parent_next == NO_NODE) ? ST_NO_ROUTE : ST_FORWARD;
        out_changed_next = (parent_next != parent_reg);
        if (is_sink_reg)
        begin
            parent_next      = '0;
            out_hop_next     = '0;
            out_status_next  = ST_LOCAL;
            out_changed_next = 1'b0;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_entry_reg <= entry_t'(s_tdata[$bits(entry_t)-1:0]);
            in_last_reg  <= s_tlast;
        end
    end

    // configuration and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_sink_reg   <= 1'b0;
            margin_reg    <= MARGIN_RESET;
            parent_reg    <= NO_NODE;
            best_id_reg   <= NO_NODE;
            best_qual_reg <= '0;
            best_hops_reg <= NO_HOPS;
            par_qual_reg  <= '0;
            par_hops_reg  <= NO_HOPS;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IS_SINK:
                    begin
                        is_sink_reg <= cfg_data[0];
                        parent_reg  <= cfg_data[0] ? '0 : NO_NODE;
                    end
                    REG_QUALITY_MARGIN:
                    begin
                        margin_reg <= cfg_data[QUAL_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (fire && (in_last_reg || !is_sink_reg))
            begin
                if (in_last_reg)
                begin
                    // decide, then clear the scan
                    parent_reg    <= parent_next;
                    best_id_reg   <= NO_NODE;
                    best_qual_reg <= '0;
                    best_hops_reg <= NO_HOPS;
                    par_qual_reg  <= '0;
                    par_hops_reg  <= NO_HOPS;
                end
                else
                begin
                    best_id_reg   <= best_id_next;
                    best_qual_reg <= best_qual_next;
                    best_hops_reg <= best_hops_next;
                    par_qual_reg  <= par_qual_next;
                    par_hops_reg  <= par_hops_next;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_last_reg)
        begin
            out_hop_reg     <= out_hop_next;
            out_status_reg  <= out_status_next;
            out_changed_reg <= out_changed_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - NODE_W - STATUS_W - 1){1'b0}},
                       out_changed_reg, out_status_reg, out_hop_reg};

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[17:16] == ST_FORWARD) || (m_tdata[17:16] == ST_NO_ROUTE) ||
                     (m_tdata[17:16] == ST_LOCAL))
        else $error("route status code out of range");

    a_no_route_hop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[17:16] != ST_LOCAL)) |->
            ((m_tdata[17:16] == ST_NO_ROUTE) == (m_tdata[15:0] == NO_NODE)))
        else $error("no-route status disagrees with next hop");

    a_local_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[17:16] == ST_LOCAL)) |->
            ((m_tdata[15:0] == '0) && !m_tdata[18]))
        else $error("local delivery result carries a parent or a change");

    a_scan_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_last_reg) |=> (best_hops_reg == NO_HOPS) && (par_qual_reg == '0))
        else $error("scan state not cleared after decision");

endmodule

>>> verif/tree_parent_selector_unit_tb.sv
// Testbench for tree_parent_selector_unit: random neighbour tables against a predictor.
module tree_parent_selector_unit_tb;
    import tps_pkg::*;

    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned ITEM_TARGET = 400;
    localparam int unsigned PHASES      = 7;

    typedef struct packed {
        logic   last;
        entry_t entry;
    } table_beat_t;

    typedef struct packed {
        logic                changed;
        logic [STATUS_W-1:0] status;
        logic [NODE_W-1:0]   next_hop;
    } route_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    table_beat_t entry_q[$];
    route_t      route_q[$];
    table_beat_t beat_on_bus;
    int unsigned mismatches = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned idle_cycles = 0;
    logic [15:0] stall_cycle = '0;
    logic [1:0]  stall_mode = '0;

    // predictor state
    logic              sink_mode = 1'b0;
    logic [QUAL_W-1:0] margin = MARGIN_RESET;
    logic [NODE_W-1:0] parent_id = NO_NODE;
    logic [NODE_W-1:0] cand_id = NO_NODE;
    logic [QUAL_W-1:0] cand_qual = '0;
    logic [HOPS_W-1:0] cand_hops = NO_HOPS;
    logic [QUAL_W-1:0] seen_qual = '0;
    logic [HOPS_W-1:0] seen_hops = NO_HOPS;

    tree_parent_selector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic void clear_scan();
        cand_id   = NO_NODE;
        cand_qual = '0;
        cand_hops = NO_HOPS;
        seen_qual = '0;
        seen_hops = NO_HOPS;
    endfunction

    function automatic void scan_entry(input table_beat_t b);
        logic              replace;
        logic [NODE_W-1:0] prior;
        route_t            r;
        if (sink_mode)
        begin
            if (b.last)
            begin
                clear_scan();
                parent_id  = '0;
                r.next_hop = '0;
                r.status   = ST_LOCAL;
                r.changed  = 1'b0;
                route_q.push_back(r);
            end
        end
        else
        begin
            if (b.entry.link_bidirectional && b.entry.component_id == '0)
            begin
                if (b.entry.neighbor_id == parent_id)
                begin
                    seen_qual = b.entry.link_quality;
                    seen_hops = b.entry.hop_distance;
                end
                if (b.entry.hop_distance < cand_hops ||
                    (b.entry.hop_distance == cand_hops && b.entry.link_quality > cand_qual))
                begin
                    cand_id   = b.entry.neighbor_id;
                    cand_qual = b.entry.link_quality;
                    cand_hops = b.entry.hop_distance;
                end
            end
            if (b.last)
            begin
                replace = (seen_qual == '0) || (cand_hops < seen_hops) ||
                          (cand_hops == seen_hops &&
                           {1'b0, cand_qual} > ({1'b0, seen_qual} + {1'b0, margin}));
                prior = parent_id;
                if (replace)
                    parent_id = cand_id;
                r.next_hop = parent_id;
                r.status   = (parent_id == NO_NODE) ? ST_NO_ROUTE : ST_FORWARD;
                r.changed  = (parent_id != prior);
                route_q.push_back(r);
                clear_scan();
            end
        end
    endfunction

    function automatic void add_entry(input logic [NODE_W-1:0] id, input logic bidir,
                                      input logic [COMP_W-1:0] comp,
                                      input logic [HOPS_W-1:0] hops,
                                      input logic [QUAL_W-1:0] qual, input logic last);
        table_beat_t b;
        b.entry.neighbor_id        = id;
        b.entry.link_bidirectional = bidir;
        b.entry.component_id       = comp;
        b.entry.hop_distance       = hops;
        b.entry.link_quality       = qual;
        b.last                     = last;
        entry_q.push_back(b);
    endfunction

    // mostly well-formed tables drawn from a small id pool; some broken noise
    task automatic push_table(output int unsigned n);
        int unsigned len;
        int unsigned pick;
        logic [NODE_W-1:0] id;
        logic [HOPS_W-1:0] hops;
        logic [QUAL_W-1:0] qual;
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                add_entry(NODE_W'($urandom), 1'($urandom_range(0, 1)), COMP_W'($urandom),
                          HOPS_W'($urandom), QUAL_W'($urandom),
                          $urandom_range(0, 2) == 0);
        end
        else
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    id = NODE_W'($urandom_range(1, 6));
                else if (pick == 6)
                    id = NO_NODE;
                else if (pick == 7)
                    id = '0;
                else
                    id = NODE_W'($urandom);
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    hops = HOPS_W'($urandom_range(0, 3));
                else if (pick == 7)
                    hops = NO_HOPS;
                else
                    hops = HOPS_W'($urandom);
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    qual = QUAL_W'($urandom_range(0, 3000));
                else if (pick == 3)
                    qual = '0;
                else if (pick == 4)
                    qual = '1;
                else
                    qual = QUAL_W'($urandom);
                add_entry(id, $urandom_range(0, 19) < 17,
                          ($urandom_range(0, 19) < 17) ? '0 : COMP_W'($urandom),
                          hops, qual, i == len - 1);
            end
            n = len;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_IS_SINK)
        begin
            sink_mode = val[0];
            parent_id = val[0] ? '0 : NO_NODE;
        end
        else
            margin = val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (entry_q.size() != 0 || s_tvalid || route_q.size() != 0);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned sink_set[PHASES];
        int unsigned margin_set[PHASES];
        int unsigned per_phase;
        int unsigned sent;
        int unsigned n;
        logic [CFG_DATA_W-1:0] m;
        sink_set   = '{0, 0, 1, 0, 0, 1, 0};
        margin_set = '{0, 65535, 1000, 1, 0, 0, 1000};
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no parent yet: first valid entry wins
        add_entry(16'd5, 1'b1, '0, 16'd2, 16'd100, 1'b1);
        // equal hops, quality exactly parent plus margin: hold parent
        add_entry(16'd5, 1'b1, '0, 16'd2, 16'd100, 1'b0);
        add_entry(16'd7, 1'b1, '0, 16'd2, 16'd1100, 1'b1);
        // one above the margin: switch
        add_entry(16'd5, 1'b1, '0, 16'd2, 16'd100, 1'b0);
        add_entry(16'd7, 1'b1, '0, 16'd2, 16'd1101, 1'b1);
        // fewer hops wins regardless of quality
        add_entry(16'd7, 1'b1, '0, 16'd3, 16'd50, 1'b0);
        add_entry(16'd9, 1'b1, '0, 16'd1, 16'd1, 1'b1);
        // parent absent, one-way and foreign-component entries ignored
        add_entry(16'd3, 1'b0, '0, 16'd0, 16'hFFFF, 1'b0);
        add_entry(16'd4, 1'b1, 16'd1, 16'd0, 16'hFFFF, 1'b0);
        add_entry(16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        add_entry(16'd8, 1'b1, '0, 16'd5, 16'd10, 1'b1);
        // replacement with no candidate: lose the route
        add_entry(16'd8, 1'b0, '0, 16'd1, 16'd500, 1'b1);
        add_entry(16'd8, 1'b0, '0, 16'd1, 16'd500, 1'b1);
        // broadcast id seen as parent at the extremes
        add_entry(16'hFFFF, 1'b1, '0, 16'd0, 16'hFFFF, 1'b1);
        add_entry(16'd0, 1'b1, '0, 16'hFFFF, 16'd1, 1'b1);
        add_entry(16'd0, 1'b1, '0, 16'hFFFF, 16'd0, 1'b1);
        // full tie: first entry holds
        add_entry(16'd2, 1'b1, '0, 16'd1, 16'd700, 1'b0);
        add_entry(16'd3, 1'b1, '0, 16'd1, 16'd700, 1'b1);
        wait_drained();

        per_phase = ITEM_TARGET / PHASES;
        for (int p = 0; p < PHASES; p++)
        begin
            m = (p == 4) ? CFG_DATA_W'($urandom) : CFG_DATA_W'(margin_set[p]);
            write_reg(REG_QUALITY_MARGIN, m);
            write_reg(REG_IS_SINK, CFG_DATA_W'(sink_set[p]));
            sent = 0;
            while (sent < per_phase)
            begin
                push_table(n);
                sent += n;
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // sender: bursts of random length, random gaps between them
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                scan_entry(beat_on_bus);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (entry_q.size() != 0)
                begin
                    beat_on_bus = entry_q.pop_front();
                    s_tdata  <= {{(IN_DATA_W - $bits(entry_t)){1'b0}}, beat_on_bus.entry};
                    s_tlast  <= beat_on_bus.last;
                    s_tvalid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall mode is redrawn whenever the low six bits of stall_cycle are zero
    always @(posedge clk)
    begin
        route_t got;
        route_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = route_t'(m_tdata[$bits(route_t)-1:0]);
                if (route_q.size() == 0)
                    flag_mismatch("result with none pending, next_hop", 32'(got.next_hop), 0);
                else
                begin
                    want = route_q.pop_front();
                    if (got.next_hop !== want.next_hop)
                        flag_mismatch("next_hop", 32'(got.next_hop), 32'(want.next_hop));
                    if (got.status !== want.status)
                        flag_mismatch("route_status", 32'(got.status), 32'(want.status));
                    if (got.changed !== want.changed)
                        flag_mismatch("parent_changed", 32'(got.changed), 32'(want.changed));
                end
            end
            stall_cycle <= stall_cycle + 1'b1;
            if (stall_cycle[5:0] == '0)
                stall_mode <= 2'($urandom_range(0, 3));
            case (stall_mode)
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= 1'($urandom_range(0, 1));
                2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= stall_cycle[1];
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
